FILE: src/ilh_pkg.sv
// ----------------------------------------------------------------------------
// ilh_pkg
// Shared types and constants for the IPv4 / L4 header parser.
// ----------------------------------------------------------------------------
package ilh_pkg;

   localparam logic [1:0]  LINK_ETHERNET = 2'd0;
   localparam logic [1:0]  LINK_COOKED   = 2'd1;

   localparam logic [15:0] VLAN_TPID     = 16'h8100;
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] FRAG_OFF_MASK = 16'h1FFF;
   localparam logic [15:0] FRAG_MF_MASK  = 16'h2000;
   localparam logic [3:0]  IP_VERSION_4  = 4'd4;

   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   localparam logic [7:0]  COUNT_MAX     = 8'hFF;

   localparam logic [8:0]  ETH_HDR_BYTES    = 9'd14;
   localparam logic [8:0]  VLAN_HDR_BYTES   = 9'd18;
   localparam logic [8:0]  COOKED_HDR_BYTES = 9'd16;
   localparam logic [5:0]  MIN_HDR_BYTES    = 6'd20;
   localparam logic [5:0]  UDP_HDR_BYTES    = 6'd8;

   localparam logic [2:0]  STATUS_PRE_IP = 3'd0;
   localparam logic [2:0]  STATUS_L4_REJ = 3'd1;
   localparam logic [2:0]  STATUS_TCP    = 3'd2;
   localparam logic [2:0]  STATUS_UDP    = 3'd3;
   localparam logic [2:0]  STATUS_ICMP   = 3'd4;
   localparam logic [2:0]  STATUS_OTHER  = 3'd5;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } in_word_type;

   typedef struct packed {
      logic [7:0]  byte_count;
      logic [15:0] type_word;
      logic        vlan_seen;
      logic [7:0]  version_ihl;
      logic [15:0] total_length;
      logic [15:0] frag_word;
      logic [7:0]  proto;
      logic [63:0] addr_pair;
      logic [31:0] ports;
      logic [3:0]  tcp_offset;
      logic [23:0] window_flags;
   } frame_state_type;

   // Highest member first so that status lands in the lowest bits.
   typedef struct packed {
      logic [15:0] payload_bytes;
      logic [23:0] window_and_flags;
      logic [5:0]  l4_hdr_bytes;
      logic [31:0] port_pair;
      logic [31:0] dest_addr;
      logic [31:0] source_addr;
      logic [15:0] ip_length;
      logic [5:0]  ip_hdr_bytes;
      logic        fragment_flag;
      logic [7:0]  ip_protocol;
      logic [15:0] ether_type;
      logic [2:0]  status;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);

endpackage

FILE: src/ipv4_l4_header_parser.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser
// Captured-frame byte stream in, one IPv4 / TCP / UDP header summary out.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, with tlast on the final byte, unless a final
// byte waits on a held result. One result word per frame is loaded into the
// result register once the final byte has left the input register, and is
// shown on rsp_tvalid. Every byte passes an input register and updates the
// field-capture registers in the following cycle, which sets the rate of one
// byte per cycle; the end-of-frame checks sit between those registers and the
// result register. Input stalls only while a finished result is held and the
// next final byte is waiting. The link type register is written through
// csr_we / csr_wdata and takes effect from the next byte.
module ipv4_l4_header_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,    // link_type
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // data_byte
   input  logic         req_tlast,    // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], ether_type[18:3], ip_protocol[26:19], fragment_flag[27],
   // ip_hdr_bytes[33:28], ip_length[49:34], source_addr[81:50],
   // dest_addr[113:82], port_pair[145:114], l4_hdr_bytes[151:146],
   // window_and_flags[175:152], payload_bytes[191:176]
   output logic [191:0] rsp_tdata
);
   import ilh_pkg::*;

   logic [1:0]      link_type_ff, link_type_in;
   logic            word_valid, advance, out_free;
   in_word_type     word;
   frame_state_type state_upd;
   result_type      result, rsp_view;

   assign link_type_in = csr_we ? csr_wdata : link_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_type_ff <= LINK_ETHERNET;
      end else begin
         link_type_ff <= link_type_in;
      end
   end

   assign advance = word_valid && (!word.last || out_free);

   ilh_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   ilh_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .link_type (link_type_ff),
      .advance   (advance),
      .word      (word),
      .state_upd (state_upd)
   );

   ilh_check u_check (
      .link_type (link_type_ff),
      .st        (state_upd),
      .res       (result)
   );

   ilh_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && word.last),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign rsp_view = result_type'(rsp_tdata);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_view.status <= STATUS_OTHER)
      else $error("status code out of range");

   a_l4_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.status != STATUS_TCP && rsp_view.status != STATUS_UDP) |->
      (rsp_view.port_pair == 32'd0 && rsp_view.l4_hdr_bytes == 6'd0 &&
       rsp_view.window_and_flags == 24'd0 && rsp_view.payload_bytes == 16'd0))
      else $error("L4 fields set on a frame without an L4 header");

   a_tcp_hdr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.status == STATUS_TCP) |->
      (rsp_view.l4_hdr_bytes >= MIN_HDR_BYTES && rsp_view.ip_hdr_bytes >= MIN_HDR_BYTES))
      else $error("TCP result with short header length");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the result register is free");

endmodule

FILE: src/ilh_in_reg.sv
// ----------------------------------------------------------------------------
// ilh_in_reg
// Input register: holds one accepted frame byte until the capture stage takes it.
// ----------------------------------------------------------------------------
module ilh_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               advance,
   output logic               word_valid,
   output ilh_pkg::in_word_type word
);
   import ilh_pkg::*;

   logic        valid_ff, valid_in;
   in_word_type word_ff, word_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_tvalid && req_tready) begin
         valid_in     = 1'b1;
         word_in.data = req_tdata;
         word_in.last = req_tlast;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

FILE: src/ilh_capture.sv
// ----------------------------------------------------------------------------
// ilh_capture
// Frame state registers: copy header fields at their offsets, one byte a cycle.
// ----------------------------------------------------------------------------
module ilh_capture (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               link_type,
   input  logic                     advance,
   input  ilh_pkg::in_word_type     word,
   output ilh_pkg::frame_state_type state_upd
);
   import ilh_pkg::*;

   frame_state_type state_ff, state_in, upd;
   logic [7:0] idx, b, off, r, s;
   logic [5:0] hl;
   logic       link_ok;

   always_comb begin
      upd     = state_ff;
      idx     = state_ff.byte_count;
      b       = word.data;
      link_ok = 1'b1;
      s       = '0;
      case (link_type)
         LINK_ETHERNET: begin
            if (idx == 8'd12 || idx == 8'd13 ||
                (state_ff.vlan_seen && (idx == 8'd16 || idx == 8'd17))) begin
               upd.type_word = {state_ff.type_word[7:0], b};
            end
            if (idx == 8'd13) begin
               upd.vlan_seen = (upd.type_word == VLAN_TPID);
            end
         end
         LINK_COOKED: begin
            if (idx == 8'd14 || idx == 8'd15) begin
               upd.type_word = {state_ff.type_word[7:0], b};
            end
         end
         default: begin
            link_ok = 1'b0;
         end
      endcase
      if (link_type == LINK_COOKED) begin
         off = COOKED_HDR_BYTES[7:0];
      end else if (upd.vlan_seen) begin
         off = VLAN_HDR_BYTES[7:0];
      end else begin
         off = ETH_HDR_BYTES[7:0];
      end
      r = idx - off;
      if (link_ok && idx >= off) begin
         case (r) inside
            8'd0:           upd.version_ihl  = b;
            8'd2, 8'd3:     upd.total_length = {state_ff.total_length[7:0], b};
            8'd6, 8'd7:     upd.frag_word    = {state_ff.frag_word[7:0], b};
            8'd9:           upd.proto        = b;
            [8'd12:8'd19]:  upd.addr_pair    = {state_ff.addr_pair[55:0], b};
            default: ;
         endcase
      end
      hl = {upd.version_ihl[3:0], 2'b00};
      if (link_ok && idx >= off && hl >= MIN_HDR_BYTES && r >= {2'b00, hl}) begin
         s = r - {2'b00, hl};
         case (s) inside
            [8'd0:8'd3]: upd.ports = {state_ff.ports[23:0], b};
            8'd12:       upd.tcp_offset = b[7:4];
            8'd13:       upd.window_flags[7:0]   = b;
            8'd14:       upd.window_flags[23:16] = b;
            8'd15:       upd.window_flags[15:8]  = b;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         if (word.last) begin
            state_in = '0;
         end else begin
            state_in = upd;
            if (state_ff.byte_count != COUNT_MAX) begin
               state_in.byte_count = state_ff.byte_count + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state_upd = upd;

endmodule

FILE: src/ilh_check.sv
// ----------------------------------------------------------------------------
// ilh_check
// End-of-frame checks: length, ethertype, version, header lengths, L4 header.
// ----------------------------------------------------------------------------
module ilh_check (
   input  logic [1:0]               link_type,
   input  ilh_pkg::frame_state_type st,
   output ilh_pkg::result_type      res
);
   import ilh_pkg::*;

   logic [8:0]  len, off, l4;
   logic [5:0]  hl, tl;
   logic        link_ok, frag;
   logic [16:0] diff;

   always_comb begin
      res  = '0;
      res.status = STATUS_PRE_IP;
      len  = {1'b0, st.byte_count} + 9'd1;
      hl   = {st.version_ihl[3:0], 2'b00};
      tl   = {st.tcp_offset, 2'b00};
      frag = ((st.frag_word & FRAG_OFF_MASK) != 16'd0) ||
             ((st.frag_word & FRAG_MF_MASK) != 16'd0);
      diff = '0;
      case (link_type)
         LINK_ETHERNET: begin
            link_ok = (len >= ETH_HDR_BYTES) && !(st.vlan_seen && len < VLAN_HDR_BYTES);
            off     = st.vlan_seen ? VLAN_HDR_BYTES : ETH_HDR_BYTES;
         end
         LINK_COOKED: begin
            link_ok = (len >= COOKED_HDR_BYTES);
            off     = COOKED_HDR_BYTES;
         end
         default: begin
            link_ok = 1'b0;
            off     = ETH_HDR_BYTES;
         end
      endcase
      l4 = off + {3'b000, hl};
      if (link_ok) begin
         res.ether_type = st.type_word;
         if (st.type_word == ETH_TYPE_IPV4 && len >= off + {3'b000, MIN_HDR_BYTES} &&
             st.version_ihl[7:4] == IP_VERSION_4 && hl >= MIN_HDR_BYTES &&
             len >= l4 && st.total_length >= {10'd0, hl}) begin
            res.ip_protocol   = st.proto;
            res.fragment_flag = frag;
            res.ip_hdr_bytes  = hl;
            res.ip_length     = st.total_length;
            res.source_addr   = st.addr_pair[63:32];
            res.dest_addr     = st.addr_pair[31:0];
            if (st.proto == PROTO_TCP && !frag) begin
               res.status = STATUS_L4_REJ;
               if (len >= l4 + {3'b000, MIN_HDR_BYTES} && tl >= MIN_HDR_BYTES &&
                   len >= l4 + {3'b000, tl}) begin
                  diff = {1'b0, st.total_length} - {11'd0, hl} - {11'd0, tl};
                  res.status           = STATUS_TCP;
                  res.port_pair        = st.ports;
                  res.l4_hdr_bytes     = tl;
                  res.window_and_flags = st.window_flags;
                  res.payload_bytes    = diff[16] ? 16'd0 : diff[15:0];
               end
            end else if (st.proto == PROTO_UDP && !frag) begin
               res.status = STATUS_L4_REJ;
               if (len >= l4 + {3'b000, UDP_HDR_BYTES}) begin
                  diff = {1'b0, st.total_length} - {11'd0, hl} - {11'd0, UDP_HDR_BYTES};
                  res.status        = STATUS_UDP;
                  res.port_pair     = st.ports;
                  res.l4_hdr_bytes  = UDP_HDR_BYTES;
                  res.payload_bytes = diff[16] ? 16'd0 : diff[15:0];
               end
            end else if (st.proto == PROTO_ICMP) begin
               res.status = STATUS_ICMP;
            end else begin
               res.status = STATUS_OTHER;
            end
         end
      end
   end

endmodule

FILE: src/ilh_out_reg.sv
// ----------------------------------------------------------------------------
// ilh_out_reg
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ilh_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  ilh_pkg::result_type           result,
   output logic                          free,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ilh_pkg::RESULT_BITS-1:0] rsp_tdata
);
   import ilh_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = result_ff;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_l4_header_parser. Builds captured frames (plain
// and tagged Ethernet, cooked headers, unknown link types) and streams them in
// byte by byte with random gaps on both sides. A predictor follows every byte
// and queues one header summary per frame; each result word is compared field
// by field against the oldest queued summary. A directed table comes first,
// then random frames, mostly well formed, with broken ones mixed in.
// ----------------------------------------------------------------------------
module testbench;
   import ilh_pkg::*;

   localparam logic [1:0] LINK_UNKNOWN   = 2'd2;
   localparam logic [1:0] LINK_RESERVED  = 2'd3;
   localparam logic [2:0] CHECK_PREDICT  = 3'd7;
   localparam int         DIRECTED_ROWS  = 26;
   localparam int         RANDOM_BYTES   = 600;
   localparam int         RANDOM_FRAMES  = 14;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         DRAIN_CYCLES   = 4;
   localparam int         WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [1:0]         link;
      logic               vlan;
      logic [15:0]        etype;
      logic [3:0]         version;
      logic [3:0]         ihl;
      logic [7:0]         proto;
      logic [15:0]        frag;
      logic [3:0]         tcp_off;
      logic [7:0]         payload;
      logic signed [15:0] tot_adj;
      logic signed [15:0] cut;
      logic [2:0]         exp_status;
      logic [15:0]        exp_ether;
   } frame_row_type;

   // link, vlan, type, version, ihl, proto, frag, tcp offset, payload,
   // total length adjust, bytes cut (negative pads), status, ether type
   localparam frame_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd5, 8'd4, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b1, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd6, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_ICMP, 16'h0000,
        4'd5, 8'd8, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, 8'hFF, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd15, PROTO_TCP, 16'h0000,
        4'd15, 8'd0, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h2000,
        4'd5, 8'd2, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b1, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h1FFF,
        4'd5, 8'd2, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd41, STATUS_PRE_IP, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd29, STATUS_PRE_IP, 16'h0000},
      '{LINK_ETHERNET, 1'b1, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd29, STATUS_PRE_IP, 16'h0000},
      '{LINK_ETHERNET, 1'b0, 16'h86DD, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd0, STATUS_PRE_IP, 16'h86DD},
      '{LINK_ETHERNET, 1'b0, 16'hFFFF, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd0, STATUS_PRE_IP, 16'hFFFF},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, 4'd6, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd0, STATUS_PRE_IP, ETH_TYPE_IPV4},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd4, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd0, STATUS_PRE_IP, ETH_TYPE_IPV4},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, -16'sd28, 16'sd0, STATUS_PRE_IP, ETH_TYPE_IPV4},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd12, STATUS_PRE_IP, ETH_TYPE_IPV4},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd10, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd4, 8'd0, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd3, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd5, 8'd4, -16'sd24, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd5, 8'd0, -16'sd41, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_ETHERNET, 1'b1, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, -16'sd258, CHECK_PREDICT, 16'h0000},
      '{LINK_COOKED, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd5, 8'd4, 16'sd0, 16'sd0, CHECK_PREDICT, 16'h0000},
      '{LINK_COOKED, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd29, STATUS_PRE_IP, 16'h0000},
      '{LINK_UNKNOWN, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 16'h0000,
        4'd5, 8'd4, 16'sd0, 16'sd0, STATUS_PRE_IP, 16'h0000},
      '{LINK_RESERVED, 1'b0, ETH_TYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 16'h0000,
        4'd5, 8'd0, 16'sd0, 16'sd0, STATUS_PRE_IP, 16'h0000}
   };

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [191:0] rsp_tdata;

   frame_state_type fst;
   logic [1:0]      link_sel;
   result_type      pending_summaries [$];
   logic [7:0]      frame_bytes [$];
   logic            typed_on;
   result_type      typed_result;
   logic [1:0]      cur_link;
   int              idle_pct;
   logic            hold_off_req;
   int              error_count;
   int              results_checked;
   int              bytes_in;
   int              frames_in;
   int              status_hist [6];
   int              quiet_cycles;

   ipv4_l4_header_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int hdr_offset();
      if (link_sel == LINK_COOKED) return int'(COOKED_HDR_BYTES);
      return fst.vlan_seen ? int'(VLAN_HDR_BYTES) : int'(ETH_HDR_BYTES);
   endfunction

   task automatic absorb_byte(input logic [7:0] b);
      int idx, off, r, hl, s;
      idx = int'(fst.byte_count);
      if (link_sel > LINK_COOKED) return;
      if (link_sel == LINK_ETHERNET) begin
         if (idx == 12 || idx == 13 || (fst.vlan_seen && (idx == 16 || idx == 17)))
            fst.type_word = {fst.type_word[7:0], b};
         if (idx == 13) fst.vlan_seen = (fst.type_word == VLAN_TPID);
      end else if (idx == 14 || idx == 15) begin
         fst.type_word = {fst.type_word[7:0], b};
      end
      off = hdr_offset();
      if (idx < off) return;
      r = idx - off;
      if (r == 0) fst.version_ihl = b;
      else if (r == 2 || r == 3) fst.total_length = {fst.total_length[7:0], b};
      else if (r == 6 || r == 7) fst.frag_word = {fst.frag_word[7:0], b};
      else if (r == 9) fst.proto = b;
      else if (r >= 12 && r <= 19) fst.addr_pair = {fst.addr_pair[55:0], b};
      hl = int'(fst.version_ihl[3:0]) * 4;
      if (hl < int'(MIN_HDR_BYTES) || r < hl) return;
      s = r - hl;
      if (s <= 3) fst.ports = {fst.ports[23:0], b};
      else if (s == 12) fst.tcp_offset = b[7:4];
      else if (s == 13) fst.window_flags[7:0] = b;
      else if (s == 14) fst.window_flags[23:16] = b;
      else if (s == 15) fst.window_flags[15:8] = b;
   endtask

   function automatic result_type frame_summary(input int len);
      result_type res;
      int         off, hl, tot, l4, tl, pay;
      logic       frag;
      res = '0;
      if (link_sel > LINK_COOKED) return res;
      off = hdr_offset();
      if (len < off) return res;
      res.ether_type = fst.type_word;
      if (fst.type_word != ETH_TYPE_IPV4 || len < off + int'(MIN_HDR_BYTES)) return res;
      if (fst.version_ihl[7:4] != IP_VERSION_4) return res;
      hl  = int'(fst.version_ihl[3:0]) * 4;
      tot = int'(fst.total_length);
      if (hl < int'(MIN_HDR_BYTES) || len < off + hl || tot < hl) return res;
      frag = |(fst.frag_word & (FRAG_OFF_MASK | FRAG_MF_MASK));
      res.ip_protocol   = fst.proto;
      res.fragment_flag = frag;
      res.ip_hdr_bytes  = 6'(hl);
      res.ip_length     = 16'(tot);
      res.source_addr   = fst.addr_pair[63:32];
      res.dest_addr     = fst.addr_pair[31:0];
      l4 = off + hl;
      if (fst.proto == PROTO_TCP && !frag) begin
         res.status = STATUS_L4_REJ;
         tl = int'(fst.tcp_offset) * 4;
         if (len < l4 + int'(MIN_HDR_BYTES) || tl < int'(MIN_HDR_BYTES) || len < l4 + tl)
            return res;
         res.status           = STATUS_TCP;
         res.port_pair        = fst.ports;
         res.l4_hdr_bytes     = 6'(tl);
         res.window_and_flags = fst.window_flags;
         pay = tot - hl - tl;
         res.payload_bytes = (pay > 0) ? 16'(pay) : 16'd0;
      end else if (fst.proto == PROTO_UDP && !frag) begin
         res.status = STATUS_L4_REJ;
         if (len < l4 + int'(UDP_HDR_BYTES)) return res;
         res.status       = STATUS_UDP;
         res.port_pair    = fst.ports;
         res.l4_hdr_bytes = UDP_HDR_BYTES;
         pay = tot - hl - int'(UDP_HDR_BYTES);
         res.payload_bytes = (pay > 0) ? 16'(pay) : 16'd0;
      end else if (fst.proto == PROTO_ICMP) begin
         res.status = STATUS_ICMP;
      end else begin
         res.status = STATUS_OTHER;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t ERROR %s: expected %0h, actual %0h", $time, name, want, seen);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want, seen;
      if (reset) begin
         link_sel = LINK_ETHERNET;
         fst      = '0;
      end else begin
         if (csr_we) link_sel = csr_wdata;
         if (req_tvalid && req_tready) begin
            bytes_in++;
            absorb_byte(req_tdata);
            if (req_tlast) begin
               want = frame_summary(int'(fst.byte_count) + 1);
               if (typed_on) want = typed_result;
               pending_summaries.push_back(want);
               frames_in++;
               fst = '0;
            end else if (fst.byte_count != COUNT_MAX) begin
               fst.byte_count++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (pending_summaries.size() == 0) begin
               $display("%0t ERROR unexpected result word: expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = pending_summaries.pop_front();
               check_field("status", 32'(want.status), 32'(seen.status));
               check_field("ether_type", 32'(want.ether_type), 32'(seen.ether_type));
               check_field("ip_protocol", 32'(want.ip_protocol), 32'(seen.ip_protocol));
               check_field("fragment_flag", 32'(want.fragment_flag),
                           32'(seen.fragment_flag));
               check_field("ip_hdr_bytes", 32'(want.ip_hdr_bytes), 32'(seen.ip_hdr_bytes));
               check_field("ip_length", 32'(want.ip_length), 32'(seen.ip_length));
               check_field("source_addr", want.source_addr, seen.source_addr);
               check_field("dest_addr", want.dest_addr, seen.dest_addr);
               check_field("port_pair", want.port_pair, seen.port_pair);
               check_field("l4_hdr_bytes", 32'(want.l4_hdr_bytes), 32'(seen.l4_hdr_bytes));
               check_field("window_and_flags", 32'(want.window_and_flags),
                           32'(seen.window_and_flags));
               check_field("payload_bytes", 32'(want.payload_bytes),
                           32'(seen.payload_bytes));
               results_checked++;
               if (want.status <= STATUS_OTHER) status_hist[want.status]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ERROR watchdog: no transfer for %0d cycles", $time, quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   initial begin
      int gap;
      bit hold_done;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            gap = pick_gap();
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void place(input int pos, input logic [7:0] value);
      if (pos < frame_bytes.size()) frame_bytes[pos] = value;
   endfunction

   function automatic void build_frame(input frame_row_type sp);
      int         off, hl, l4len, tot, len;
      logic [3:0] nib;
      logic [15:0] tot16;
      if (sp.link == LINK_COOKED) off = int'(COOKED_HDR_BYTES);
      else if (sp.link == LINK_ETHERNET && sp.vlan) off = int'(VLAN_HDR_BYTES);
      else off = int'(ETH_HDR_BYTES);
      hl = int'(sp.ihl) * 4;
      if (hl < int'(MIN_HDR_BYTES)) hl = int'(MIN_HDR_BYTES);
      l4len = int'(UDP_HDR_BYTES);
      if (sp.proto == PROTO_TCP) begin
         l4len = int'(sp.tcp_off) * 4;
         if (l4len < int'(MIN_HDR_BYTES)) l4len = int'(MIN_HDR_BYTES);
      end
      tot   = hl + l4len + int'(sp.payload) + int'(sp.tot_adj);
      tot16 = tot[15:0];
      len   = off + hl + l4len + int'(sp.payload) - int'(sp.cut);
      if (len < 1) len = 1;
      frame_bytes.delete();
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (sp.link == LINK_COOKED) begin
         place(14, sp.etype[15:8]);
         place(15, sp.etype[7:0]);
      end else if (sp.link == LINK_ETHERNET && sp.vlan) begin
         place(12, VLAN_TPID[15:8]);
         place(13, VLAN_TPID[7:0]);
         place(16, sp.etype[15:8]);
         place(17, sp.etype[7:0]);
      end else begin
         place(12, sp.etype[15:8]);
         place(13, sp.etype[7:0]);
      end
      place(off, {sp.version, sp.ihl});
      place(off + 2, tot16[15:8]);
      place(off + 3, tot16[7:0]);
      place(off + 6, sp.frag[15:8]);
      place(off + 7, sp.frag[7:0]);
      place(off + 9, sp.proto);
      nib = 4'($urandom_range(0, 15));
      if (sp.proto == PROTO_TCP) place(off + hl + 12, {sp.tcp_off, nib});
   endfunction

   function automatic frame_row_type random_frame(input logic [1:0] lt);
      frame_row_type sp;
      int            pick;
      sp.link    = lt;
      sp.vlan    = ($urandom_range(0, 3) == 0);
      sp.etype   = ETH_TYPE_IPV4;
      sp.version = IP_VERSION_4;
      sp.ihl     = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      pick       = $urandom_range(0, 19);
      if (pick < 9) sp.proto = PROTO_TCP;
      else if (pick < 16) sp.proto = PROTO_UDP;
      else if (pick < 18) sp.proto = PROTO_ICMP;
      else sp.proto = 8'($urandom_range(0, 255));
      sp.frag    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF)) : 16'd0;
      sp.tcp_off = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      sp.payload = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(17, 255))
                                                  : 8'($urandom_range(0, 16));
      sp.tot_adj    = '0;
      sp.cut        = '0;
      sp.exp_status = CHECK_PREDICT;
      sp.exp_ether  = '0;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 6))
            0: sp.etype = 16'($urandom_range(0, 16'hFFFF));
            1: sp.version = 4'($urandom_range(0, 15));
            2: sp.ihl = 4'($urandom_range(0, 15));
            3: sp.tcp_off = 4'($urandom_range(0, 15));
            4: sp.cut = 16'($urandom_range(1, 60));
            5: sp.tot_adj = 16'($urandom_range(0, 16'hFFFF));
            default: sp.cut = 16'(-int'($urandom_range(180, 260)));
         endcase
      end
      return sp;
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = pick_gap();
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_summaries.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_link(input logic [1:0] lt);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= lt;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      cur_link = lt;
   endtask

   initial begin
      frame_row_type sp;
      int            bytes_sent, frames_sent, pick;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = LINK_ETHERNET;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      typed_on     = 1'b0;
      typed_result = '0;
      cur_link     = LINK_ETHERNET;
      idle_pct     = 10;
      hold_off_req = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         sp = DIRECTED[row];
         if (sp.link != cur_link) write_link(sp.link);
         build_frame(sp);
         typed_on     = (sp.exp_status != CHECK_PREDICT);
         typed_result = '0;
         typed_result.status     = sp.exp_status;
         typed_result.ether_type = sp.exp_ether;
         send_frame();
         typed_on = 1'b0;
      end

      bytes_sent  = 0;
      frames_sent = 0;
      while (bytes_sent < RANDOM_BYTES || frames_sent < RANDOM_FRAMES) begin
         if (frames_sent % 8 == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) write_link(LINK_ETHERNET);
            else if (pick < 8) write_link(LINK_COOKED);
            else if (pick < 9) write_link(LINK_UNKNOWN);
            else write_link(LINK_RESERVED);
            pick = $urandom_range(0, 2);
            idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
         end
         // hold the sink off while frames keep arriving
         if (frames_sent == 12) hold_off_req = 1'b1;
         build_frame(random_frame(cur_link));
         send_frame();
         bytes_sent += frame_bytes.size();
         frames_sent++;
      end

      req_tvalid <= 1'b0;
      while (pending_summaries.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES * 4) @(negedge clock);
      if (pending_summaries.size() != 0) begin
         $display("%0t ERROR %0d expected results never arrived", $time,
                  pending_summaries.size());
      end

      $display("Covered %0d frames in %0d bytes over all link settings, %0d results checked",
               frames_in, bytes_in, results_checked);
      $display("By status: pre-ip %0d, l4-reject %0d, tcp %0d, udp %0d, icmp %0d, other %0d",
               status_hist[STATUS_PRE_IP], status_hist[STATUS_L4_REJ],
               status_hist[STATUS_TCP], status_hist[STATUS_UDP],
               status_hist[STATUS_ICMP], status_hist[STATUS_OTHER]);
      if (error_count == 0 && pending_summaries.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
